// ===== design/plst_pkg.sv =====
// Package for the positional list store: sizes, command and status codes,
// and the control word that the top level broadcasts to every cell.
// No dependencies.
`default_nettype none

package plst_pkg;

  localparam int CAPACITY = 16;                      // entries held, 1..64
  localparam int CNT_W    = $clog2(CAPACITY + 1);    // holds 0..CAPACITY
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int ECNT_W   = 7;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_COUNT     = 3'd6,
    CMD_DUMP      = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // What every cell does this cycle.
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,   // open a gap at idx, shift the tail toward the back
    CM_DELETE,   // close the slot at idx, shift the tail toward the front
    CM_ROTATE    // move the occupied part one step toward the front, head wraps
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e               mode;
    logic [CNT_W-1:0]         idx;
    logic [CNT_W-1:0]         occ;
    logic signed [DATA_W-1:0] data;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/plst_cmd_if.sv =====
// Command channel of the positional list store: valid/ready plus one command.
// Depends on plst_pkg.
`default_nettype none

interface plst_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        command;
  logic signed [plst_pkg::DATA_W-1:0] value;
  logic [plst_pkg::POS_W-1:0]        position;

  modport source (output valid, output command, output value, output position,
                  input ready);
  modport sink   (input valid, input command, input value, input position,
                  output ready);
endinterface

`default_nettype wire

// ===== design/plst_res_if.sv =====
// Result channel of the positional list store: valid/ready plus one result.
// Depends on plst_pkg.
`default_nettype none

interface plst_res_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic [plst_pkg::ECNT_W-1:0]        entry_count;
  logic signed [plst_pkg::DATA_W-1:0] element;
  logic                               last;

  modport source (output valid, output status, output entry_count, output element,
                  output last, input ready);
  modport sink   (input valid, input status, input entry_count, input element,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== design/positional_list_store_unit.sv =====
// Positional list store: an ordered list of up to CAPACITY signed 32-bit
// entries held in a chain of cells that all shift in the same cycle. Every
// command except a dump of a non-empty list gives one result, so such
// commands stream at one per cycle while the result register is free or being
// drained; a new command is taken in the cycle in which the previous result
// leaves the result register, and waits while that result is stalled. A dump
// of n entries gives n results after the command transfer, one result per
// cycle unless the sink stalls: the chain rotates its occupied part one step
// toward the front for each result and the front cell is read out, so after
// n steps the order is restored. No command is taken while a dump runs.
// Insert and delete positions are 1-based; bad positions, full and empty
// cases report a status and leave the list as is.
// Depends on plst_pkg, plst_cmd_if, plst_res_if and plst_chain.
`default_nettype none

module positional_list_store_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  plst_cmd_if.sink   cmd,
  plst_res_if.source res
);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  state_e                             state;
  logic [plst_pkg::CNT_W-1:0]         occ;
  logic [plst_pkg::CNT_W-1:0]         occ_next;
  logic [plst_pkg::CNT_W-1:0]         dump_cnt;

  // Result register
  logic                               res_valid;
  plst_pkg::status_e                  res_status;
  logic [plst_pkg::ECNT_W-1:0]        res_count;
  logic signed [plst_pkg::DATA_W-1:0] res_element;
  logic                               res_last;

  logic                               out_free;
  logic                               accept;
  logic                               start_dump;
  logic                               dump_last;
  logic                               res_load;
  plst_pkg::status_e                  status;
  plst_pkg::cell_ctrl_t               ctrl;
  plst_pkg::cmd_e                     code;
  logic [plst_pkg::POS_W:0]           pos_ext;
  logic [plst_pkg::POS_W:0]           occ_ext;
  logic                               full;
  logic signed [plst_pkg::DATA_W-1:0] head;

  assign out_free  = !res_valid || res.ready;
  assign cmd.ready = (state == S_IDLE) && out_free;
  assign accept    = cmd.valid && cmd.ready;
  assign code      = plst_pkg::cmd_e'(cmd.command);
  assign pos_ext   = {1'b0, cmd.position};
  assign occ_ext   = (plst_pkg::POS_W + 1)'(occ);
  assign full      = (occ == plst_pkg::CNT_W'(plst_pkg::CAPACITY));
  assign dump_last = (dump_cnt == occ - 1'b1);
  // Load the result register on a plain command or on each dump step.
  assign res_load  = (state == S_IDLE) ? (accept && !start_dump) : out_free;

  // Decode the command and drive the cell chain.
  always_comb begin
    ctrl.mode  = plst_pkg::CM_HOLD;
    ctrl.idx   = '0;
    ctrl.occ   = occ;
    ctrl.data  = cmd.value;
    status     = plst_pkg::ST_OK;
    occ_next   = occ;
    start_dump = 1'b0;
    if (state == S_DUMP) begin
      if (out_free) begin
        ctrl.mode = plst_pkg::CM_ROTATE;
      end
    end else if (accept) begin
      unique case (code)
        plst_pkg::CMD_INS_FRONT, plst_pkg::CMD_INS_BACK: begin
          if (full) begin
            status = plst_pkg::ST_FULL;
          end else begin
            ctrl.mode = plst_pkg::CM_INSERT;
            ctrl.idx  = (code == plst_pkg::CMD_INS_FRONT) ? '0 : occ;
            occ_next  = occ + 1'b1;
          end
        end
        plst_pkg::CMD_INS_AT: begin
          if (pos_ext == '0 || pos_ext > occ_ext + 1'b1) begin
            status = plst_pkg::ST_BADPOS;
          end else if (full) begin
            status = plst_pkg::ST_FULL;
          end else begin
            ctrl.mode = plst_pkg::CM_INSERT;
            ctrl.idx  = plst_pkg::CNT_W'(cmd.position - 1'b1);
            occ_next  = occ + 1'b1;
          end
        end
        plst_pkg::CMD_DEL_FRONT, plst_pkg::CMD_DEL_BACK: begin
          if (occ == '0) begin
            status = plst_pkg::ST_EMPTY;
          end else begin
            ctrl.mode = plst_pkg::CM_DELETE;
            ctrl.idx  = (code == plst_pkg::CMD_DEL_FRONT) ? '0 : occ - 1'b1;
            occ_next  = occ - 1'b1;
          end
        end
        plst_pkg::CMD_DEL_AT: begin
          if (occ == '0) begin
            status = plst_pkg::ST_EMPTY;
          end else if (pos_ext == '0 || pos_ext > occ_ext) begin
            status = plst_pkg::ST_BADPOS;
          end else begin
            ctrl.mode = plst_pkg::CM_DELETE;
            ctrl.idx  = plst_pkg::CNT_W'(cmd.position - 1'b1);
            occ_next  = occ - 1'b1;
          end
        end
        plst_pkg::CMD_COUNT: ;
        plst_pkg::CMD_DUMP: begin
          start_dump = (occ != '0);
        end
        default: ;
      endcase
    end
  end

  plst_chain u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .head (head)
  );

  // State, count and result register. Payload fields are loaded together with
  // res_valid and need no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      dump_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      occ <= occ_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (start_dump) begin
              state    <= S_DUMP;
              dump_cnt <= '0;
            end else begin
              res_status  <= status;
              res_count   <= plst_pkg::ECNT_W'(occ_next);
              res_element <= '0;
              res_last    <= 1'b1;
            end
          end
        end
        S_DUMP: begin
          // Read the front cell while the chain rotates past it.
          if (out_free) begin
            res_status  <= plst_pkg::ST_OK;
            res_count   <= plst_pkg::ECNT_W'(occ);
            res_element <= head;
            res_last    <= dump_last;
            dump_cnt    <= dump_cnt + 1'b1;
            if (dump_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid       = res_valid;
  assign res.status      = res_status;
  assign res.entry_count = res_count;
  assign res.element     = res_element;
  assign res.last        = res_last;

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= plst_pkg::CNT_W'(plst_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_occ_only_on_transfer: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(occ))
    else $error("entry count changed without a command transfer");

  a_no_cmd_in_dump: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> !cmd.ready)
    else $error("command taken during dump");

  a_dump_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP && out_free && dump_last |=> state == S_IDLE && res_valid && res_last)
    else $error("dump did not end on its final entry");

  a_dump_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> dump_cnt < occ)
    else $error("dump index past entry count");

endmodule

`default_nettype wire

// ===== design/plst_cell.sv =====
// One storage cell of the list chain: holds one entry and picks its next
// value from the load data or a neighbor. Depends on plst_pkg.
`default_nettype none

module plst_cell (
  input  wire logic                                clk,
  input  wire logic [plst_pkg::CNT_W-1:0]          index,
  input  wire plst_pkg::cell_ctrl_t                ctrl,
  input  wire logic signed [plst_pkg::DATA_W-1:0]  prev_value,
  input  wire logic signed [plst_pkg::DATA_W-1:0]  next_value,
  input  wire logic signed [plst_pkg::DATA_W-1:0]  head_value,
  output logic signed [plst_pkg::DATA_W-1:0]       value
);

  logic [plst_pkg::CNT_W:0]           index_p1;
  logic [plst_pkg::CNT_W:0]           occ_ext;
  logic signed [plst_pkg::DATA_W-1:0] value_next;

  assign index_p1 = {1'b0, index} + 1'b1;
  assign occ_ext  = {1'b0, ctrl.occ};

  always_comb begin
    value_next = value;
    unique case (ctrl.mode)
      plst_pkg::CM_HOLD: ;
      plst_pkg::CM_INSERT: begin
        if (index == ctrl.idx) begin
          value_next = ctrl.data;
        end else if (index > ctrl.idx && index <= ctrl.occ) begin
          value_next = prev_value;
        end
      end
      plst_pkg::CM_DELETE: begin
        if (index >= ctrl.idx && index_p1 < occ_ext) begin
          value_next = next_value;
        end
      end
      plst_pkg::CM_ROTATE: begin
        if (index_p1 < occ_ext) begin
          value_next = next_value;
        end else if (index_p1 == occ_ext) begin
          value_next = head_value;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

// ===== design/plst_chain.sv =====
// Row of CAPACITY list cells wired to their neighbors; cell 0 is the front.
// Depends on plst_pkg and plst_cell.
`default_nettype none

module plst_chain (
  input  wire logic                                clk,
  input  wire plst_pkg::cell_ctrl_t                ctrl,
  output logic signed [plst_pkg::DATA_W-1:0]       head
);

  logic signed [plst_pkg::DATA_W-1:0] cell_value [plst_pkg::CAPACITY];

  for (genvar i = 0; i < plst_pkg::CAPACITY; i++) begin : g_cell
    logic signed [plst_pkg::DATA_W-1:0] prev_v;
    logic signed [plst_pkg::DATA_W-1:0] next_v;

    // End cells never take from the missing side; tie it to themselves.
    if (i == 0) begin : g_first
      assign prev_v = cell_value[i];
    end else begin : g_mid_prev
      assign prev_v = cell_value[i-1];
    end
    if (i == plst_pkg::CAPACITY - 1) begin : g_last
      assign next_v = cell_value[i];
    end else begin : g_mid_next
      assign next_v = cell_value[i+1];
    end

    plst_cell u_cell (
      .clk        (clk),
      .index      (plst_pkg::CNT_W'(i)),
      .ctrl       (ctrl),
      .prev_value (prev_v),
      .next_value (next_v),
      .head_value (cell_value[0]),
      .value      (cell_value[i])
    );
  end

  assign head = cell_value[0];

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the positional list store: a scoreboard class
// mirrors the list and checks every result transfer; plain tasks drive commands.
// Depends on plst_pkg, plst_cmd_if, plst_res_if and positional_list_store_unit.
`default_nettype none

typedef struct packed {
  plst_pkg::status_e                  status;
  logic [plst_pkg::ECNT_W-1:0]        entry_count;
  logic signed [plst_pkg::DATA_W-1:0] element;
  logic                               last;
} list_result_t;

class list_scoreboard;
  logic signed [plst_pkg::DATA_W-1:0] cells [plst_pkg::CAPACITY];
  int unsigned                        fill;
  list_result_t                       awaited_q[$];
  int unsigned                        errors;

  function new();
    fill   = 0;
    errors = 0;
  endfunction

  // Open a gap at slot at and place v there.
  function void open_gap(int unsigned at, logic signed [plst_pkg::DATA_W-1:0] v);
    int unsigned i;
    for (i = fill; i > at; i--) cells[i] = cells[i-1];
    cells[at] = v;
    fill++;
  endfunction

  // Close slot at, pulling the tail one step toward the front.
  function void close_slot(int unsigned at);
    int unsigned i;
    for (i = at; i + 1 < fill; i++) cells[i] = cells[i+1];
    fill--;
  endfunction

  // Update the list for one accepted command and queue the results it causes.
  function void note_command(plst_pkg::cmd_e op, logic signed [plst_pkg::DATA_W-1:0] v,
                             logic [plst_pkg::POS_W-1:0] p);
    plst_pkg::status_e st;
    list_result_t      r;
    int unsigned       i;
    st = plst_pkg::ST_OK;
    case (op)
      plst_pkg::CMD_INS_FRONT, plst_pkg::CMD_INS_BACK: begin
        if (fill >= plst_pkg::CAPACITY) st = plst_pkg::ST_FULL;
        else open_gap((op == plst_pkg::CMD_INS_FRONT) ? 0 : fill, v);
      end
      plst_pkg::CMD_INS_AT: begin
        if (p < 1 || p > fill + 1) st = plst_pkg::ST_BADPOS;
        else if (fill >= plst_pkg::CAPACITY) st = plst_pkg::ST_FULL;
        else open_gap(p - 1, v);
      end
      plst_pkg::CMD_DEL_FRONT, plst_pkg::CMD_DEL_BACK: begin
        if (fill == 0) st = plst_pkg::ST_EMPTY;
        else close_slot((op == plst_pkg::CMD_DEL_FRONT) ? 0 : fill - 1);
      end
      plst_pkg::CMD_DEL_AT: begin
        if (fill == 0) st = plst_pkg::ST_EMPTY;
        else if (p < 1 || p > fill) st = plst_pkg::ST_BADPOS;
        else close_slot(p - 1);
      end
      plst_pkg::CMD_DUMP: begin
        if (fill != 0) begin
          for (i = 0; i < fill; i++) begin
            r.status      = plst_pkg::ST_OK;
            r.entry_count = plst_pkg::ECNT_W'(fill);
            r.element     = cells[i];
            r.last        = (i + 1 == fill);
            awaited_q.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.status      = st;
    r.entry_count = plst_pkg::ECNT_W'(fill);
    r.element     = '0;
    r.last        = 1'b1;
    awaited_q.push_back(r);
  endfunction

  task report(string msg);
    if (errors < 50) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic [1:0] st, logic [plst_pkg::ECNT_W-1:0] cnt,
                    logic signed [plst_pkg::DATA_W-1:0] el, logic lst);
    list_result_t want;
    if (awaited_q.size() == 0) begin
      report($sformatf("result with nothing outstanding: status %0d count %0d element %0d",
                       st, cnt, el));
      return;
    end
    want = awaited_q.pop_front();
    if (st !== want.status)
      report($sformatf("status %0d, expected %0d", st, want.status));
    if (cnt !== want.entry_count)
      report($sformatf("entry_count %0d, expected %0d", cnt, want.entry_count));
    if (el !== want.element)
      report($sformatf("element %0d, expected %0d", el, want.element));
    if (lst !== want.last)
      report($sformatf("last %0b, expected %0b", lst, want.last));
  endtask

  function int pending();
    return awaited_q.size();
  endfunction
endclass

module tb_top;

  localparam int QUIET_LIMIT    = 1000;  // cycles with no transfer before giving up
  localparam int HOLDOFF_CYCLES = 60;    // long receiver stall in the pressure phase
  localparam int PHASE_ITEMS    = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;

  plst_cmd_if cmd_bus();
  plst_res_if res_bus();

  positional_list_store_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  list_scoreboard sb = new();

  int tx_idle_pct   = 0;   // chance of a sender gap before each command
  int rx_stall_pct  = 0;   // chance the receiver drops ready in a cycle
  bit holdoff_start = 1'b0;
  int holdoff_left  = 0;
  bit grow_bias     = 1'b1;  // steer random commands toward filling or draining
  int quiet_cycles  = 0;

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off counted here when requested.
  always @(posedge clk) begin
    if (holdoff_start) begin
      holdoff_left  = HOLDOFF_CYCLES;
      holdoff_start = 1'b0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready)
      sb.check_result(res_bus.status, res_bus.entry_count, res_bus.element, res_bus.last);
  end

  // Watchdog: abort when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one command and hold it until the transfer; note it in the scoreboard.
  // Entered and left right after a rising edge, so valid gets one update per edge.
  task issue_command(plst_pkg::cmd_e op, logic signed [plst_pkg::DATA_W-1:0] v,
                     logic [plst_pkg::POS_W-1:0] p);
    if ($urandom_range(99, 0) < tx_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < tx_idle_pct);
    end
    cmd_bus.valid    <= 1'b1;
    cmd_bus.command  <= op;
    cmd_bus.value    <= v;
    cmd_bus.position <= p;
    do @(posedge clk); while (!(cmd_bus.valid && cmd_bus.ready));
    sb.note_command(op, v, p);
  endtask

  // Mostly well-formed positions; now and then any position at all.
  task issue_random_command();
    int                         pick;
    plst_pkg::cmd_e             op;
    logic [plst_pkg::POS_W-1:0] p;
    if (sb.fill >= plst_pkg::CAPACITY) grow_bias = 1'b0;
    else if (sb.fill == 0) grow_bias = 1'b1;
    else if ($urandom_range(99, 0) < 5) grow_bias = ~grow_bias;
    pick = $urandom_range(99, 0);
    if (pick < (grow_bias ? 60 : 30)) begin
      case ($urandom_range(2, 0))
        0:       op = plst_pkg::CMD_INS_FRONT;
        1:       op = plst_pkg::CMD_INS_BACK;
        default: op = plst_pkg::CMD_INS_AT;
      endcase
    end else if (pick < 85) begin
      case ($urandom_range(2, 0))
        0:       op = plst_pkg::CMD_DEL_FRONT;
        1:       op = plst_pkg::CMD_DEL_BACK;
        default: op = plst_pkg::CMD_DEL_AT;
      endcase
    end else if (pick < 92) begin
      op = plst_pkg::CMD_COUNT;
    end else begin
      op = plst_pkg::CMD_DUMP;
    end
    p = plst_pkg::POS_W'($urandom_range(127, 0));
    if ($urandom_range(99, 0) < 85) begin
      if (op == plst_pkg::CMD_INS_AT)
        p = plst_pkg::POS_W'($urandom_range(sb.fill + 1, 1));
      else if (op == plst_pkg::CMD_DEL_AT && sb.fill > 0)
        p = plst_pkg::POS_W'($urandom_range(sb.fill, 1));
    end
    issue_command(op, $urandom, p);
  endtask

  // Drop valid and hold until every expected result has arrived.
  task wait_for_drain();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task run_random_phase(int tx_pct, int rx_pct, int n);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (n) issue_random_command();
    wait_for_drain();
  endtask

  initial begin
    // Drive every command input to a known value before the first edge.
    cmd_bus.valid    = 1'b0;
    cmd_bus.command  = plst_pkg::CMD_COUNT;
    cmd_bus.value    = '0;
    cmd_bus.position = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store first.
    issue_command(plst_pkg::CMD_COUNT, 32'sd0, 7'd0);
    issue_command(plst_pkg::CMD_DUMP, 32'sd0, 7'd0);          // empty dump gives one result
    issue_command(plst_pkg::CMD_DEL_FRONT, 32'sd0, 7'd1);     // delete on empty
    issue_command(plst_pkg::CMD_DEL_AT, 32'sd0, 7'd0);        // empty wins over bad position
    issue_command(plst_pkg::CMD_INS_AT, 32'sd5, 7'd0);        // position zero is invalid
    issue_command(plst_pkg::CMD_INS_AT, 32'sd5, 7'd2);        // one past count+1
    issue_command(plst_pkg::CMD_INS_AT, 32'h8000_0000, 7'd1);
    issue_command(plst_pkg::CMD_INS_BACK, 32'h7fff_ffff, 7'd0);
    issue_command(plst_pkg::CMD_INS_FRONT, 32'hffff_ffff, 7'd127);
    issue_command(plst_pkg::CMD_INS_AT, 32'sd7, 7'd127);      // far out of range
    issue_command(plst_pkg::CMD_DEL_AT, 32'sd0, 7'd0);
    issue_command(plst_pkg::CMD_DEL_AT, 32'sd0, 7'd4);        // one past count
    issue_command(plst_pkg::CMD_DEL_AT, 32'sd0, 7'd2);
    // Fill up with inserts at random legal positions.
    while (sb.fill < plst_pkg::CAPACITY)
      issue_command(plst_pkg::CMD_INS_AT, $urandom,
                    plst_pkg::POS_W'($urandom_range(sb.fill + 1, 1)));
    issue_command(plst_pkg::CMD_INS_FRONT, 32'sd1, 7'd0);     // full
    issue_command(plst_pkg::CMD_INS_AT, 32'sd1, 7'd127);      // bad position wins over full
    issue_command(plst_pkg::CMD_INS_AT, 32'sd1, 7'd3);        // full
    issue_command(plst_pkg::CMD_DUMP, 32'sd0, 7'd0);          // full-length dump
    issue_command(plst_pkg::CMD_DEL_BACK, 32'sd0, 7'd0);
    issue_command(plst_pkg::CMD_DEL_FRONT, 32'sd0, 7'd0);
    issue_command(plst_pkg::CMD_COUNT, 32'sd0, 7'd0);

    // Random phases with different idling on each side.
    run_random_phase(0, 0, PHASE_ITEMS);
    run_random_phase(69, 0, PHASE_ITEMS);
    run_random_phase(0, 69, PHASE_ITEMS);
    run_random_phase(38, 38, PHASE_ITEMS);

    // Pressure: receiver holds off while commands keep coming, so input stalls.
    holdoff_start = 1'b1;
    run_random_phase(0, 0, 14);

    // Let any stray result show up before closing.
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== positional_list_store_unit.f =====
design/plst_pkg.sv
design/plst_cmd_if.sv
design/plst_res_if.sv
design/plst_cell.sv
design/plst_chain.sv
design/positional_list_store_unit.sv
test/tb_top.sv
